FILE: rtl/core/tcpa_pkg.sv
// Shared types, constants and the divide step for the true-colour pixel to ARGB converter.
// No dependencies; used by tcpa_div_pipe and true_color_pixel_to_argb_top.
package tcpa_pkg;

  // Channel divide: 32-bit dividend, 4 restoring steps per pipeline stage
  localparam int DIV_BITS        = 32;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = DIV_BITS / STEPS_PER_STAGE;
  localparam int NUM_STAGES      = DIV_STAGES + 1;

  localparam int CHAN_W     = 8;
  localparam int PART_W     = DIV_BITS - CHAN_W;
  localparam int REM_W      = 16;
  localparam int DIVISOR_W  = REM_W + 1;
  localparam int SHIFT_W    = 5;
  localparam int BPP_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [BPP_W-1:0] BPP_FOUR = 3'd4;
  localparam logic [BPP_W-1:0] BPP_TWO  = 3'd2;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPP,
    REG_RED_SHIFT,
    REG_GREEN_SHIFT,
    REG_BLUE_SHIFT,
    REG_RED_MAX,
    REG_GREEN_MAX,
    REG_BLUE_MAX,
    REG_SWAP_RB
  } cfg_reg_t;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [DIV_BITS-1:0] word;
  } div_state_t;

  typedef struct packed {
    logic mask_set;
    logic last;
  } side_t;

  // One restoring step: shift a dividend bit into the remainder, shift the
  // quotient bit into the bottom of the word.
  function automatic div_state_t div_step(div_state_t s, logic [DIVISOR_W-1:0] d);
    logic [DIVISOR_W-1:0] trial;
    div_state_t r;
    trial = {s.rem, s.word[DIV_BITS-1]};
    if (trial >= d) begin
      r.rem  = REM_W'(trial - d);
      r.word = {s.word[DIV_BITS-2:0], 1'b1};
    end else begin
      r.rem  = trial[REM_W-1:0];
      r.word = {s.word[DIV_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/tcpa_div_pipe.sv
// Pipelined restoring divider for one colour channel: (part * 256) / divisor, low 8 bits.
// Depends on tcpa_pkg; stage enables come from the top level's valid chain.
module tcpa_div_pipe (
  input  logic                                 clk,
  input  logic [tcpa_pkg::NUM_STAGES-1:0]      stage_en,
  input  logic [tcpa_pkg::PART_W-1:0]          part,
  input  logic [tcpa_pkg::DIVISOR_W-1:0]       divisor,
  output logic [tcpa_pkg::CHAN_W-1:0]          quot
);

  tcpa_pkg::div_state_t st_r  [tcpa_pkg::NUM_STAGES];
  tcpa_pkg::div_state_t st_nxt[tcpa_pkg::NUM_STAGES];

  always_comb begin
    tcpa_pkg::div_state_t s;
    st_nxt[0].rem  = '0;
    st_nxt[0].word = {part, {tcpa_pkg::CHAN_W{1'b0}}};
    for (int k = 1; k < tcpa_pkg::NUM_STAGES; k++) begin
      s = st_r[k-1];
      for (int j = 0; j < tcpa_pkg::STEPS_PER_STAGE; j++) begin
        s = tcpa_pkg::div_step(s, divisor);
      end
      st_nxt[k] = s;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < tcpa_pkg::NUM_STAGES; k++) begin
      if (stage_en[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // After all steps the word holds the quotient; keep its low byte
  assign quot = st_r[tcpa_pkg::NUM_STAGES-1].word[tcpa_pkg::CHAN_W-1:0];

endmodule

FILE: rtl/core/true_color_pixel_to_argb_top.sv
// Top level of the true-colour pixel to ARGB converter: config registers, valid chain, packing.
// Depends on tcpa_pkg and tcpa_div_pipe (one per colour channel).
//
// Usage:
//   Input beats (in_pixel_value, in_mask_set, in_last_in) are taken on in_valid && in_ready;
//   result beats (out_argb_word, out_last_out) leave on out_valid && out_ready, in order.
//   Each pixel is cut to 1, 2 or 4 bytes, each channel is shifted down and scaled as
//   (part * 256) / (max + 1), keeping the low byte; alpha is 0xFF for a set mask bit.
//   Nine register stages: one for byte cut and barrel shift, then 8 divider stages of
//   4 restoring steps each (32 steps per channel). Throughput is one pixel per clock
//   while out_ready is high; the three channel dividers run side by side.
//   Each stage holds its beat while the one ahead is full and stalled, so in_ready
//   stays high while any bubble remains in the pipe even if out_ready is low.
//   Config writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once; the user must make
//   them only while the pipe is empty, which the block does not enforce; max regs hold max + 1.
//   Synchronous reset empties the pipe and loads 4 bytes per pixel, shifts 16/8/0,
//   max 255 on every channel and no red/blue swap.
module true_color_pixel_to_argb_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [31:0]                        in_pixel_value,
  input  logic                               in_mask_set,
  input  logic                               in_last_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [31:0]                        out_argb_word,
  output logic                               out_last_out,
  input  logic                               cfg_wr_en,
  input  logic [tcpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcpa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int LAST = tcpa_pkg::NUM_STAGES - 1;

  logic [tcpa_pkg::BPP_W-1:0]     bpp_r;
  logic [tcpa_pkg::SHIFT_W-1:0]   red_shift_r;
  logic [tcpa_pkg::SHIFT_W-1:0]   green_shift_r;
  logic [tcpa_pkg::SHIFT_W-1:0]   blue_shift_r;
  logic [tcpa_pkg::DIVISOR_W-1:0] red_div_r;
  logic [tcpa_pkg::DIVISOR_W-1:0] green_div_r;
  logic [tcpa_pkg::DIVISOR_W-1:0] blue_div_r;
  logic                           swap_r;

  logic [tcpa_pkg::NUM_STAGES-1:0] vld_r;
  logic [tcpa_pkg::NUM_STAGES-1:0] vld_nxt;
  logic [tcpa_pkg::NUM_STAGES-1:0] stage_en;
  tcpa_pkg::side_t                 side_r [tcpa_pkg::NUM_STAGES];

  logic [31:0]                  pix_cut;
  logic [tcpa_pkg::PART_W-1:0]  red_part;
  logic [tcpa_pkg::PART_W-1:0]  green_part;
  logic [tcpa_pkg::PART_W-1:0]  blue_part;
  logic [tcpa_pkg::CHAN_W-1:0]  red_q;
  logic [tcpa_pkg::CHAN_W-1:0]  green_q;
  logic [tcpa_pkg::CHAN_W-1:0]  blue_q;
  logic [tcpa_pkg::CHAN_W-1:0]  alpha;

  // Configuration registers; max values stored as divisor (max + 1)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r         <= tcpa_pkg::BPP_FOUR;
      red_shift_r   <= 5'd16;
      green_shift_r <= 5'd8;
      blue_shift_r  <= 5'd0;
      red_div_r     <= 17'd256;
      green_div_r   <= 17'd256;
      blue_div_r    <= 17'd256;
      swap_r        <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (tcpa_pkg::cfg_reg_t'(cfg_index))
        tcpa_pkg::REG_BPP:         bpp_r         <= cfg_wdata[tcpa_pkg::BPP_W-1:0];
        tcpa_pkg::REG_RED_SHIFT:   red_shift_r   <= cfg_wdata[tcpa_pkg::SHIFT_W-1:0];
        tcpa_pkg::REG_GREEN_SHIFT: green_shift_r <= cfg_wdata[tcpa_pkg::SHIFT_W-1:0];
        tcpa_pkg::REG_BLUE_SHIFT:  blue_shift_r  <= cfg_wdata[tcpa_pkg::SHIFT_W-1:0];
        tcpa_pkg::REG_RED_MAX:     red_div_r     <= {1'b0, cfg_wdata} + 17'd1;
        tcpa_pkg::REG_GREEN_MAX:   green_div_r   <= {1'b0, cfg_wdata} + 17'd1;
        tcpa_pkg::REG_BLUE_MAX:    blue_div_r    <= {1'b0, cfg_wdata} + 17'd1;
        tcpa_pkg::REG_SWAP_RB:     swap_r        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Stage k advances when empty or when the stage ahead advances
  always_comb begin
    stage_en[LAST] = !vld_r[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
    vld_nxt[0] = stage_en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < tcpa_pkg::NUM_STAGES; k++) begin
      vld_nxt[k] = stage_en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign in_ready = stage_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      side_r[0].mask_set <= in_mask_set;
      side_r[0].last     <= in_last_in;
    end
    for (int k = 1; k < tcpa_pkg::NUM_STAGES; k++) begin
      if (stage_en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Cut the pixel to its size, then shift each channel down
  always_comb begin
    case (bpp_r)
      tcpa_pkg::BPP_FOUR: pix_cut = in_pixel_value;
      tcpa_pkg::BPP_TWO:  pix_cut = {16'h0000, in_pixel_value[15:0]};
      default:            pix_cut = {24'h000000, in_pixel_value[7:0]};
    endcase
  end

  assign red_part   = tcpa_pkg::PART_W'(pix_cut >> red_shift_r);
  assign green_part = tcpa_pkg::PART_W'(pix_cut >> green_shift_r);
  assign blue_part  = tcpa_pkg::PART_W'(pix_cut >> blue_shift_r);

  tcpa_div_pipe u_red_div (
    .clk      (clk),
    .stage_en (stage_en),
    .part     (red_part),
    .divisor  (red_div_r),
    .quot     (red_q)
  );

  tcpa_div_pipe u_green_div (
    .clk      (clk),
    .stage_en (stage_en),
    .part     (green_part),
    .divisor  (green_div_r),
    .quot     (green_q)
  );

  tcpa_div_pipe u_blue_div (
    .clk      (clk),
    .stage_en (stage_en),
    .part     (blue_part),
    .divisor  (blue_div_r),
    .quot     (blue_q)
  );

  assign alpha = side_r[LAST].mask_set ? tcpa_pkg::ALPHA_OPAQUE : tcpa_pkg::ALPHA_CLEAR;

  assign out_valid     = vld_r[LAST];
  assign out_last_out  = side_r[LAST].last;
  assign out_argb_word = swap_r ? {alpha, blue_q, green_q, red_q}
                                : {alpha, red_q, green_q, blue_q};

  // A ready sink must let the whole pipe advance
  a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // A stalled middle stage keeps its beat
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && !stage_en[5]) |=> vld_r[4])
    else $error("stalled stage lost its beat");

  // Alpha is only ever fully opaque or fully clear
  a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_argb_word[31:24] == tcpa_pkg::ALPHA_OPAQUE ||
                   out_argb_word[31:24] == tcpa_pkg::ALPHA_CLEAR))
    else $error("alpha byte neither opaque nor clear");

  // Reset empties every stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipe not empty after reset");

endmodule
